FILE: hw/rtl/imuafp_pkg.sv
// ----------------------------------------------------------------------------
// IMU angle frame parser package
// Frame layout constants, phase codes and field widths shared by the parser.
// ----------------------------------------------------------------------------
package imuafp_pkg;

    localparam int BYTE_W    = 8;
    localparam int PHASE_W   = 4;
    localparam int YAW_W     = 16;
    localparam int YAW_DEG_W = 24;

    typedef logic [BYTE_W-1:0]           byte_t;
    typedef logic [PHASE_W-1:0]          phase_t;
    typedef logic signed [YAW_W-1:0]     yaw_t;
    typedef logic signed [YAW_DEG_W-1:0] yaw_deg_t;

    localparam byte_t HDR_BYTE   = 8'h55;
    localparam byte_t TYPE_RESET = 8'h53;

    localparam phase_t PHASE_HUNT       = 4'd0;
    localparam phase_t PHASE_TYPE       = 4'd1;
    localparam phase_t PHASE_DATA_FIRST = 4'd2;
    localparam phase_t PHASE_YAW_LO     = 4'd6;
    localparam phase_t PHASE_YAW_HI     = 4'd7;
    localparam phase_t PHASE_DATA_LAST  = 4'd9;
    localparam phase_t PHASE_CSUM       = 4'd10;

    localparam yaw_deg_t DEG_SCALE = 24'sd180;

endpackage

FILE: hw/rtl/imu_angle_frame_parser.sv
// ----------------------------------------------------------------------------
// IMU angle frame parser
// Streaming hunt for 11-byte sensor frames (0x55, frame type, nine bytes),
// 8-bit checksum over bytes 0 to 9, one result per frame with the yaw word
// and the yaw in degrees as Q15.
//
//   channel   | dir | tdata                         | tuser
//   ----------+-----+-------------------------------+-----------------
//   s_axis    | in  | [7:0] rx_byte                 | -
//   m_axis    | out | [15:0] yaw_raw,               | [0] status
//             |     | [39:16] yaw_degrees_q15       |
//   cfg       | in  | [7:0] frame_type (write only) | -
//
// One byte is taken per cycle unless a checksum byte meets a waiting result;
// the phase counter and running sum update in the cycle of the transfer.
// A result appears in the cycle after the checksum byte, held in the output
// register until taken. While a result waits, bytes other than a checksum
// byte keep flowing. Reset clears the hunt and sets frame_type to 0x53.
// ----------------------------------------------------------------------------
module imu_angle_frame_parser (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  imuafp_pkg::byte_t                   cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  imuafp_pkg::byte_t                   s_axis_tdata,   // [7:0] rx_byte
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [imuafp_pkg::YAW_W+imuafp_pkg::YAW_DEG_W-1:0]
                                                m_axis_tdata,   // [15:0] yaw_raw,
                                                                // [39:16] yaw_degrees_q15
    output logic                                m_axis_tuser    // [0] status
);

    import imuafp_pkg::*;

    byte_t    frame_type_reg;
    phase_t   phase_reg, phase_next;
    byte_t    sum_reg, sum_next;
    byte_t    yaw_lo_reg, yaw_lo_next;
    byte_t    yaw_hi_reg, yaw_hi_next;
    logic     out_valid_reg;
    logic     status_reg;
    yaw_t     yaw_raw_reg;
    yaw_deg_t yaw_deg_reg;

    logic     in_xfer;
    logic     res_load;
    logic     csum_good;
    yaw_t     yaw_word;
    yaw_deg_t yaw_deg;

    assign s_axis_tready = !out_valid_reg || m_axis_tready || (phase_reg != PHASE_CSUM);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    assign yaw_word  = yaw_t'({yaw_hi_reg, yaw_lo_reg});
    assign yaw_deg   = yaw_deg_t'(yaw_deg_t'(yaw_word) * DEG_SCALE);
    assign csum_good = (s_axis_tdata == sum_reg);

    always_comb
    begin
        phase_next  = phase_reg;
        sum_next    = sum_reg;
        yaw_lo_next = yaw_lo_reg;
        yaw_hi_next = yaw_hi_reg;
        res_load    = 1'b0;
        if (in_xfer)
        begin
            case (phase_reg) inside
                PHASE_TYPE:
                begin
                    if (s_axis_tdata == frame_type_reg)
                    begin
                        sum_next   = sum_reg + s_axis_tdata;
                        phase_next = PHASE_DATA_FIRST;
                    end
                    else if (s_axis_tdata == HDR_BYTE)
                    begin
                        phase_next = PHASE_TYPE;
                        sum_next   = HDR_BYTE;
                    end
                    else
                    begin
                        phase_next = PHASE_HUNT;
                        sum_next   = '0;
                    end
                end
                [PHASE_DATA_FIRST:PHASE_DATA_LAST]:
                begin
                    if (phase_reg == PHASE_YAW_LO)
                    begin
                        yaw_lo_next = s_axis_tdata;
                    end
                    if (phase_reg == PHASE_YAW_HI)
                    begin
                        yaw_hi_next = s_axis_tdata;
                    end
                    sum_next   = sum_reg + s_axis_tdata;
                    phase_next = phase_reg + phase_t'(1);
                end
                PHASE_CSUM:
                begin
                    res_load   = 1'b1;
                    phase_next = PHASE_HUNT;
                    sum_next   = '0;
                end
                default:
                begin
                    if (s_axis_tdata == HDR_BYTE)
                    begin
                        phase_next = PHASE_TYPE;
                        sum_next   = HDR_BYTE;
                    end
                    else
                    begin
                        phase_next = PHASE_HUNT;
                        sum_next   = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_type_reg <= TYPE_RESET;
            phase_reg      <= PHASE_HUNT;
            sum_reg        <= '0;
            yaw_lo_reg     <= '0;
            yaw_hi_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                frame_type_reg <= cfg_data;
            end
            phase_reg  <= phase_next;
            sum_reg    <= sum_next;
            yaw_lo_reg <= yaw_lo_next;
            yaw_hi_reg <= yaw_hi_next;
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // hold the result until the output transfer
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            status_reg  <= !csum_good;
            yaw_raw_reg <= csum_good ? yaw_word : '0;
            yaw_deg_reg <= csum_good ? yaw_deg : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tdata  = {yaw_deg_reg, yaw_raw_reg};

endmodule
